### hdl/linear_probe_hash_table_defines.svh
// Assertion macros for the hash table checker
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Check on every clock edge outside reset
`define LPHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check on every clock edge, reset included
`define LPHT_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/lpht_pkg.sv
package lpht_pkg;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int STEP_W   = 5;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 7;
    localparam int TS_W     = 8;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [1:0]          sstate_t;

    // Request codes
    localparam func_t FN_INSERT = 2'd0;
    localparam func_t FN_SEARCH = 2'd1;
    localparam func_t FN_REMOVE = 2'd2;

    // Slot states
    localparam sstate_t ST_EMPTY    = 2'd0;
    localparam sstate_t ST_OCCUPIED = 2'd1;
    localparam sstate_t ST_DELETED  = 2'd2;

    // Result codes
    localparam status_t RS_OK      = 2'd0;
    localparam status_t RS_FULL    = 2'd1;
    localparam status_t RS_MISSING = 2'd2;

    // Register map (word index)
    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic [TS_W-1:0] TS_RESET = 8'd128;

    // Key written into a removed slot
    localparam key_t KEY_TOMB = '1;

    // Write strobes towards the slot memories
    typedef struct packed {
        logic we_key;
        logic we_state;
    } mem_ctl_t;

endpackage

### hdl/lpht_home.sv
module lpht_home #(
    parameter int SLOTS = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  lpht_pkg::key_t                key,
    input  logic [$clog2(SLOTS+1)-1:0]    m,
    output logic                          done,
    output logic [$clog2(SLOTS)-1:0]      home
);
    import lpht_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int MW = $clog2(SLOTS + 1);

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    key_t              dvd_reg, dvd_next;
    logic [MW-1:0]     rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic [SW-1:0]     home_reg, home_next;
    logic [MW:0]       trial;
    logic [MW:0]       trial_sub;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial     = {rem_reg, dvd_reg[KEY_W-1]};
    assign trial_sub = trial - {1'b0, m};

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        home_next = home_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = key[KEY_W-1];
            dvd_next  = key[KEY_W-1] ? (~key + 1'b1) : key;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            rem_next = (trial >= {1'b0, m}) ? trial_sub[MW-1:0] : trial[MW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(KEY_W - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            // Fold a negative remainder back into range
            if (neg_reg && (rem_reg != '0)) begin
                home_next = SW'(m - rem_reg);
            end else begin
                home_next = SW'(rem_reg);
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        home_reg <= home_next;
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

### hdl/lpht_slot_mem.sv
module lpht_slot_mem #(
    parameter int SLOTS = 128
) (
    input  logic                       aclk,
    input  lpht_pkg::mem_ctl_t         ctl,
    input  logic [$clog2(SLOTS)-1:0]   addr,
    input  lpht_pkg::key_t             wr_key,
    input  lpht_pkg::sstate_t          wr_state,
    output lpht_pkg::key_t             rd_key,
    output lpht_pkg::sstate_t          rd_state
);
    import lpht_pkg::*;

    key_t    key_mem   [SLOTS];
    sstate_t state_mem [SLOTS];
    key_t    rd_key_reg;
    sstate_t rd_state_reg;

    // Key store: written on insert and remove, read every cycle
    always_ff @(posedge aclk) begin
        if (ctl.we_key) begin
            key_mem[addr] <= wr_key;
        end
        rd_key_reg <= key_mem[addr];
    end

    // Slot state store: also swept to empty after reset
    always_ff @(posedge aclk) begin
        if (ctl.we_state) begin
            state_mem[addr] <= wr_state;
        end
        rd_state_reg <= state_mem[addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_state = rd_state_reg;

endmodule

### hdl/linear_probe_hash_table.sv
// The home slot comes from a one-bit-per-cycle remainder unit (32 steps plus a fold step);
// each probe is then a slot memory read followed by its evaluation (with write-back).
// One item in flight at a time; the next is taken once the result sits in the output register.
// Reset: synchronous, active low; table_size returns to 128, then a clearing pass over every
// slot marks each one empty, during which no item is accepted.
module linear_probe_hash_table #(
    parameter int SLOTS = 128
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lpht_pkg::func_t                      s_func,
    input  lpht_pkg::key_t                       s_key,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lpht_pkg::status_t                    m_status,
    output lpht_pkg::slot_t                      m_slot,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lpht_pkg::PADDR_W-1:0]         paddr,
    input  logic [lpht_pkg::APB_W-1:0]           pwdata,
    output logic [lpht_pkg::APB_W-1:0]           prdata,
    output logic                                 pready
);
    import lpht_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int MW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_HOLD  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [SW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]   j_reg, j_next;
    logic [MW-1:0]   cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    logic [TS_W-1:0] ts_reg;

    func_t           func_reg;
    key_t            key_reg;
    logic [MW-1:0]   m_reg;
    status_t         res_status_reg, res_status_next;
    slot_t           res_slot_reg, res_slot_next;
    status_t         m_status_reg;
    slot_t           m_slot_reg;

    logic            in_acc;
    logic            out_free;
    logic            cfg_wr;
    logic [MW-1:0]   m_eff;
    logic            hash_done;
    logic [SW-1:0]   home;
    mem_ctl_t        mem_ctl;
    logic [SW-1:0]   mem_addr;
    key_t            wr_key;
    sstate_t         wr_state;
    key_t            rd_key;
    sstate_t         rd_state;
    logic            last_probe;
    logic            fin;
    status_t         fin_status;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg <= TS_RESET;
        end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_TABLE_SIZE)) begin
            ts_reg <= pwdata[TS_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_TABLE_SIZE: prdata = {{(APB_W-TS_W){1'b0}}, ts_reg};
            default:        prdata = '0;
        endcase
    end

    // Clamp table size into 1..SLOTS
    always_comb begin
        if (ts_reg == '0) begin
            m_eff = MW'(1);
        end else if (32'(ts_reg) > SLOTS) begin
            m_eff = MW'(SLOTS);
        end else begin
            m_eff = MW'(ts_reg);
        end
    end

    lpht_home #(
        .SLOTS (SLOTS)
    ) u_home (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_acc),
        .key     (s_key),
        .m       (m_eff),
        .done    (hash_done),
        .home    (home)
    );

    lpht_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .aclk     (aclk),
        .ctl      (mem_ctl),
        .addr     (mem_addr),
        .wr_key   (wr_key),
        .wr_state (wr_state),
        .rd_key   (rd_key),
        .rd_state (rd_state)
    );

    assign mem_addr   = (state_reg == S_CLEAR) ? clr_cnt_reg : j_reg;
    assign last_probe = (cnt_reg == (m_reg - 1'b1));

    // Evaluate the slot just read; write back on insert or remove; mark slots empty while clearing
    always_comb begin
        mem_ctl    = '0;
        wr_key     = key_reg;
        wr_state   = ST_EMPTY;
        fin        = 1'b0;
        fin_status = RS_MISSING;
        if (state_reg == S_CLEAR) begin
            mem_ctl.we_state = 1'b1;
        end else if (state_reg == S_EVAL) begin
            case (func_reg) inside
                FN_INSERT: begin
                    if (rd_state != ST_OCCUPIED) begin
                        mem_ctl.we_key   = 1'b1;
                        mem_ctl.we_state = 1'b1;
                        wr_state         = ST_OCCUPIED;
                        fin              = 1'b1;
                        fin_status       = RS_OK;
                    end else if (last_probe) begin
                        fin        = 1'b1;
                        fin_status = RS_FULL;
                    end
                end
                FN_SEARCH, FN_REMOVE: begin
                    if ((rd_state == ST_OCCUPIED) && (rd_key == key_reg)) begin
                        fin        = 1'b1;
                        fin_status = RS_OK;
                        if (func_reg == FN_REMOVE) begin
                            mem_ctl.we_key   = 1'b1;
                            mem_ctl.we_state = 1'b1;
                            wr_state         = ST_DELETED;
                            wr_key           = KEY_TOMB;
                        end
                    end else if ((rd_state == ST_EMPTY) || last_probe) begin
                        fin = 1'b1;
                    end
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        j_next          = j_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SW'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    j_next     = home;
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (fin) begin
                    res_status_next = fin_status;
                    res_slot_next   = (fin_status == RS_OK) ? SLOT_W'(j_reg) : '0;
                    state_next      = S_HOLD;
                end else begin
                    // Advance to the next slot, wrapping at the table size
                    j_next     = (j_reg == SW'(m_reg - 1'b1)) ? '0 : j_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            j_reg       <= j_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            func_reg <= s_func;
            key_reg  <= s_key;
            m_reg    <= m_eff;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if ((state_reg == S_HOLD) && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

endmodule

### hdl/lpht_checker.sv
`include "linear_probe_hash_table_defines.svh"

module lpht_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input lpht_pkg::func_t               s_func,
    input lpht_pkg::key_t                s_key,
    input logic                          m_valid,
    input logic                          m_ready,
    input lpht_pkg::status_t             m_status,
    input lpht_pkg::slot_t               m_slot,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [lpht_pkg::PADDR_W-1:0]  paddr,
    input logic [lpht_pkg::APB_W-1:0]    pwdata,
    input logic [lpht_pkg::APB_W-1:0]    prdata,
    input logic                          pready
);
    import lpht_pkg::*;

    logic [1:0] out_cnt_reg, out_cnt_next;

    // Track items taken but not yet answered
    always_comb begin
        out_cnt_next = out_cnt_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= '0;
        end else begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    `LPHT_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot), "result changed while stalled")
    `LPHT_ASSERT(a_slot_zero, m_valid && (m_status != RS_OK) |-> (m_slot == '0), "failed request reports a slot")
    `LPHT_ASSERT(a_no_spurious, m_valid |-> (out_cnt_reg != 2'd0), "result without an outstanding item")
    `LPHT_ASSERT_NORST(a_reset_quiet, !aresetn |=> !s_ready && !m_valid, "channels active after reset")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
